// ----- src/asn1_te_pkg.sv -----
// Shared types, constants and tables for the ASN.1 time to epoch converter.
package asn1_te_pkg;

  localparam logic [7:0] CHAR_ZERO = 8'd48;
  localparam logic [7:0] CHAR_Z    = 8'd90;
  localparam logic [4:0] POS_MAX   = 5'd31;
  localparam logic [4:0] FIELD_END = 5'd10;

  localparam logic [1:0] FORM_UTC = 2'd0;
  localparam logic [1:0] FORM_GEN = 2'd1;

  localparam int DIV_DW = 17;
  localparam int DIV_RW = 9;
  localparam int DIV_PW = 35;
  localparam logic [DIV_DW-1:0] DIV_MONTHS = 17'd12;
  localparam logic [DIV_DW-1:0] DIV_ERA    = 17'd400;

  // 2^21/12 and 2^26/400 rounded up; exact for any 17-bit dividend
  localparam logic [17:0] RECIP_MONTHS = 18'd174763;
  localparam logic [17:0] RECIP_ERA    = 18'd167773;
  localparam int SHIFT_MONTHS = 21;
  localparam int SHIFT_ERA    = 26;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_KIND   = 2'd1,
    ERR_LEN    = 2'd2,
    ERR_SUFFIX = 2'd3
  } err_t;

  typedef enum logic [2:0] {
    S_ACC,
    S_EVAL,
    S_DIVM,
    S_DIVY,
    S_DAYS,
    S_SECS,
    S_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic take;
    logic start_m;
    logic start_y;
    logic calc_a;
    logic calc_b;
    logic calc_c;
    logic load;
  } dp_cmd_t;

  typedef struct packed {
    logic err_none;
    logic div_busy;
  } dp_status_t;

  // Day of year at the start of a month, March-based month index.
  function automatic logic [8:0] month_doy(input logic [3:0] mp);
    logic [8:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Whole centuries in a year of era (0..399).
  function automatic logic [1:0] yoe_cent(input logic [8:0] yoe);
    logic [1:0] r;
    if (yoe >= 9'd300) begin
      r = 2'd3;
    end else if (yoe >= 9'd200) begin
      r = 2'd2;
    end else if (yoe >= 9'd100) begin
      r = 2'd1;
    end else begin
      r = 2'd0;
    end
    return r;
  endfunction

endpackage

// ----- src/asn1_te_div.sv -----
// Constant divider by 12 or 400: reciprocal multiply, then remainder by back-multiply.
module asn1_te_div
  import asn1_te_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIV_DW-1:0] dividend,
  input  logic              by_era,
  output logic              busy,
  output logic [DIV_DW-1:0] quot,
  output logic [DIV_RW-1:0] rem
);

  logic [1:0]        count;
  logic [DIV_DW-1:0] num;
  logic              era;
  logic [DIV_PW-1:0] prod;
  logic [DIV_DW-1:0] back;

  assign busy = (count != 2'd0);
  assign prod = DIV_PW'(num) * DIV_PW'(era ? RECIP_ERA : RECIP_MONTHS);
  assign back = quot * (era ? DIV_ERA : DIV_MONTHS);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (start) begin
      count <= 2'd2;
    end else if (busy) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      era <= by_era;
    end else if (count == 2'd2) begin
      quot <= era ? DIV_DW'(prod[DIV_PW-1:SHIFT_ERA]) : DIV_DW'(prod[DIV_PW-1:SHIFT_MONTHS]);
    end else if (count == 2'd1) begin
      rem <= DIV_RW'(num - back);
    end
  end

endmodule

// ----- src/asn1_te_dp.sv -----
// Datapath: digit accumulators, checks, civil date arithmetic, result register.
module asn1_te_dp
  import asn1_te_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  output dp_status_t         status,
  input  logic [7:0]         char_byte,
  input  logic [1:0]         time_form,
  input  logic               last_char,
  output logic signed [40:0] epoch_seconds,
  output logic [1:0]         error_code
);

  logic [4:0]  pos;
  logic [1:0]  held_form;
  logic [15:0] year_acc, mon_acc, day_acc, hour_acc, min_acc, sec_acc;
  err_t        err_r;
  logic signed [16:0] year_r;
  logic [3:0]  mp;
  logic [24:0] p1;
  logic [17:0] doe;
  logic signed [26:0] days;
  logic signed [40:0] dprod;
  logic signed [28:0] hms;

  logic [1:0]  form_cur;
  logic [4:0]  year_len;
  logic [4:0]  rel;
  err_t        err_cur;
  logic signed [16:0] ys, y_utc, year_cur;

  logic              div_start, div_busy;
  logic [DIV_DW-1:0] div_dividend, div_quot;
  logic [DIV_RW-1:0] div_rem;
  logic              rem_le1;
  logic signed [18:0] dm_sum, dy_sum;
  logic [25:0]       p1_full;
  logic [17:0]       doe_next;
  logic signed [26:0] days_next;
  logic signed [43:0] dprod_full;
  logic signed [28:0] hms_next;
  logic signed [40:0] secs_sum;

  function automatic logic [15:0] push(input logic [15:0] acc, input logic [7:0] b);
    return 16'((acc << 3) + (acc << 1) + {8'b0, b} - {8'b0, CHAR_ZERO});
  endfunction

  assign form_cur = (pos == 5'd0) ? time_form : held_form;
  assign year_len = (form_cur == FORM_GEN) ? 5'd4 : 5'd2;
  assign rel      = pos - year_len;

  always_comb begin
    if (form_cur != FORM_UTC && form_cur != FORM_GEN) begin
      err_cur = ERR_KIND;
    end else if (pos != year_len + FIELD_END) begin
      err_cur = ERR_LEN;
    end else if (char_byte != CHAR_Z) begin
      err_cur = ERR_SUFFIX;
    end else begin
      err_cur = ERR_NONE;
    end
  end

  assign ys    = 17'($signed(year_acc));
  assign y_utc = ys + 17'sd1900;
  always_comb begin
    if (form_cur == FORM_UTC) begin
      year_cur = (y_utc < 17'sd1950) ? (y_utc + 17'sd100) : y_utc;
    end else begin
      year_cur = ys;
    end
  end

  // Accumulators and per-string state
  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      year_acc <= '0;
      mon_acc  <= '0;
      day_acc  <= '0;
      hour_acc <= '0;
      min_acc  <= '0;
      sec_acc  <= '0;
    end else if (cmd.take) begin
      if (pos < year_len) begin
        year_acc <= push(year_acc, char_byte);
      end else if (rel < FIELD_END) begin
        case (rel[3:1])
          3'd0:    mon_acc  <= push(mon_acc, char_byte);
          3'd1:    day_acc  <= push(day_acc, char_byte);
          3'd2:    hour_acc <= push(hour_acc, char_byte);
          3'd3:    min_acc  <= push(min_acc, char_byte);
          3'd4:    sec_acc  <= push(sec_acc, char_byte);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      held_form <= '0;
    end else if (cmd.take) begin
      if (last_char) begin
        pos       <= '0;
        held_form <= '0;
      end else begin
        held_form <= form_cur;
        if (pos != POS_MAX) begin
          pos <= pos + 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      err_r <= ERR_NONE;
    end else if (cmd.take && last_char) begin
      err_r <= err_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && last_char) begin
      year_r <= year_cur;
    end
  end

  // Divider: month by 12 then shifted year by 400, both offset to stay non-negative
  assign rem_le1      = (div_rem <= 9'd1);
  assign dm_sum       = 19'($signed(mon_acc)) + 19'sd32771;
  assign dy_sum       = 19'(year_r) + $signed({2'b00, div_quot})
                      + (rem_le1 ? 19'sd37268 : 19'sd37269);
  assign div_start    = cmd.start_m | cmd.start_y;
  assign div_dividend = cmd.start_m ? dm_sum[DIV_DW-1:0] : dy_sum[DIV_DW-1:0];

  asn1_te_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .by_era   (cmd.start_y),
    .busy     (div_busy),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.start_y) begin
      mp <= rem_le1 ? (div_rem[3:0] + 4'd10) : (div_rem[3:0] - 4'd2);
    end
  end

  assign p1_full  = {18'b0, div_quot[7:0]} * 26'd146097;
  assign doe_next = 18'(div_rem) * 18'd365 + 18'(div_rem[8:2])
                  - 18'(yoe_cent(div_rem)) + 18'(month_doy(mp));
  assign days_next = $signed({2'b00, p1}) + $signed({9'b0, doe})
                   + 27'($signed(day_acc)) - 27'sd15329169;
  assign dprod_full = days * 44'sd86400;
  assign hms_next   = $signed(hour_acc) * 29'sd3600 + $signed(min_acc) * 29'sd60;
  assign secs_sum   = dprod + 41'(hms) + 41'($signed(sec_acc));

  always_ff @(posedge clk) begin
    if (cmd.calc_a) begin
      p1  <= p1_full[24:0];
      doe <= doe_next;
    end
    if (cmd.calc_b) begin
      days <= days_next;
    end
    if (cmd.calc_c) begin
      dprod <= dprod_full[40:0];
      hms   <= hms_next;
    end
    if (cmd.load) begin
      epoch_seconds <= (err_r == ERR_NONE) ? secs_sum : '0;
      error_code    <= err_r;
    end
  end

  assign status.err_none = (err_r == ERR_NONE);
  assign status.div_busy = div_busy;

endmodule

// ----- src/asn1_te_ctrl.sv -----
// Controller: sequences accumulation, conversion steps and the result handshake.
module asn1_te_ctrl
  import asn1_te_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       last_char,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_ACC;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_ACC: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          if (last_char) begin
            state_next = S_EVAL;
          end
        end
      end
      S_EVAL: begin
        if (status.err_none) begin
          cmd.start_m = 1'b1;
          state_next  = S_DIVM;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DIVM: begin
        if (!status.div_busy) begin
          cmd.start_y = 1'b1;
          state_next  = S_DIVY;
        end
      end
      S_DIVY: begin
        if (!status.div_busy) begin
          cmd.calc_a = 1'b1;
          state_next = S_DAYS;
        end
      end
      S_DAYS: begin
        cmd.calc_b = 1'b1;
        state_next = S_SECS;
      end
      S_SECS: begin
        cmd.calc_c = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.load   = 1'b1;
          state_next = S_ACC;
        end
      end
      default: state_next = S_ACC;
    endcase
  end

endmodule

// ----- src/asn1_time_to_epoch_seconds.sv -----
// Top level: ASN.1 UTCTime/GeneralizedTime characters in, Unix epoch seconds out.
//
//   channel  handshake            payload
//   in       in_valid / in_ready  char_byte, time_form, last_char
//   out      out_valid/out_ready  epoch_seconds, error_code
//
// One character per cycle is taken while a string is being collected.
// After the final character, a good string goes through the check, two passes
// of the shared constant divider, then the day, second and load steps before
// the next transaction is taken. An error result goes from the check straight
// to the load step. The result sits in an output register, so a stalled out
// channel only holds the block once the next string is finished.
// Synchronous reset clears accumulators, position and error and drops out_valid.
module asn1_time_to_epoch_seconds
  import asn1_te_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         char_byte,
  input  logic [1:0]         time_form,
  input  logic               last_char,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [40:0] epoch_seconds,
  output logic [1:0]         error_code
);

  dp_cmd_t    cmd;
  dp_status_t status;

  asn1_te_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .last_char (last_char),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  asn1_te_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .char_byte     (char_byte),
    .time_form     (time_form),
    .last_char     (last_char),
    .epoch_seconds (epoch_seconds),
    .error_code    (error_code)
  );

endmodule
